// ===== rtl/smr_pkg.sv =====
// Shared types and constants for the softmax row block.
// No dependencies; imported by softmax_row_top, smr_div and the bench.
`default_nettype none

package smr_pkg;

   localparam int SCORE_W     = 16;
   localparam int PROB_W      = 16;
   localparam int EXP_W       = 17;
   localparam int TOTAL_W     = 23;
   localparam int MAX_LEN_DEF = 64;

   // Widths of the exponential series datapath.
   localparam int N_W    = 12;
   localparam int TERM_W = 51;
   localparam int ACC_W  = 54;
   localparam int PROD_W = TERM_W + N_W;
   localparam int K_W    = 7;
   localparam int DIV_W  = 56;

   localparam logic [16:0]       EXP_CUTOFF = 17'd3072;
   localparam logic [K_W-1:0]    K_LAST     = 7'd127;
   localparam logic [TERM_W-1:0] TERM_ONE   = TERM_W'(64'd1 << 36);
   localparam logic [DIV_W-1:0]  RECIP_NUM  = DIV_W'(64'd1 << 52);
   localparam logic signed [SCORE_W-1:0] SCORE_MIN = 16'sh8000;
   localparam logic [PROB_W-1:0] PROB_MAX   = 16'hFFFF;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic               row_end;
   } req_type;

   typedef struct packed {
      logic [PROB_W-1:0] probability;
      logic              result_last;
      logic              overflowed;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXP_READ,
      ST_EXP_INIT,
      ST_MUL,
      ST_DIV_K,
      ST_WAIT_K,
      ST_RECIP,
      ST_WAIT_RECIP,
      ST_EXP_WRITE,
      ST_NORM_READ,
      ST_NORM_START,
      ST_NORM_WAIT
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/softmax_row_top.sv =====
// Softmax over one row: the scores are loaded one at a time while idle, then per element an
// exp series on a serial multiplier and a shared divider, then normalization.
// Uses smr_pkg, smr_ram and smr_div.
// Each item that does not end a row is taken while idle. A row end starts the series for
//   every element, skipped for an element past the cutoff, then the normalizing divides;
//   terms <= 127 per element, each series term a serial multiply and a divide of 56 steps.
//   Results leave one at a time, each when its normalizing divide is done.
// Rows are handled one at a time; busy stays high until the last result is shown.
// Reset: synchronous, clears the element count, maximum, overflow flag and the sequencer.
`default_nettype none

module softmax_row_top
   import smr_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_valid,
   output rsp_type      rsp_item
);

   localparam int ADDR_W = $clog2(MAX_LEN);
   localparam int CNT_W  = $clog2(MAX_LEN + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);

   state_type state_ff, state_in;

   logic [CNT_W-1:0]          count_ff, count_in;
   logic signed [SCORE_W-1:0] max_ff, max_in;
   logic                      ovf_ff, ovf_in;
   logic [CNT_W-1:0]          idx_ff, idx_in;
   logic [TOTAL_W-1:0]        total_ff, total_in;
   logic [N_W-1:0]            n_ff, n_in;
   logic [TERM_W-1:0]         term_ff, term_in;
   logic [ACC_W-1:0]          acc_ff, acc_in;
   logic [PROD_W-1:0]         prod_ff, prod_in;
   logic [N_W-1:0]            mplier_ff, mplier_in;
   logic [3:0]                bit_ff, bit_in;
   logic [K_W-1:0]            k_ff, k_in;
   logic [EXP_W-1:0]          e_ff, e_in;

   logic                 accept;
   logic                 last_idx;
   logic [16:0]          n_full;
   logic                 cutoff;
   logic [TERM_W-1:0]    q_term;
   logic                 series_end;
   logic [SCORE_W-1:0]   score_rd;
   logic [EXP_W-1:0]     exp_rd;
   logic                 score_wr, score_rd_en, exp_wr, exp_rd_en;
   logic                 div_start, div_done;
   logic [DIV_W-1:0]     div_dividend, div_divisor, div_q;

   assign accept     = start && !busy;
   assign last_idx   = (idx_ff == count_ff - 1'b1);
   assign n_full     = {max_ff[SCORE_W-1], max_ff} - {score_rd[SCORE_W-1], score_rd};
   assign cutoff     = (n_full > EXP_CUTOFF);
   assign q_term     = div_q[TERM_W-1:0];
   assign series_end = (q_term == '0) || (k_ff == K_LAST);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:       if (accept && req_item.row_end) state_in = ST_EXP_READ;
         ST_EXP_READ:   state_in = ST_EXP_INIT;
         ST_EXP_INIT:   state_in = cutoff ? ST_EXP_WRITE : ST_MUL;
         ST_MUL:        if (bit_ff == 4'(N_W - 1)) state_in = ST_DIV_K;
         ST_DIV_K:      state_in = ST_WAIT_K;
         ST_WAIT_K:     if (div_done) state_in = series_end ? ST_RECIP : ST_MUL;
         ST_RECIP:      state_in = ST_WAIT_RECIP;
         ST_WAIT_RECIP: if (div_done) state_in = ST_EXP_WRITE;
         ST_EXP_WRITE:  state_in = last_idx ? ST_NORM_READ : ST_EXP_READ;
         ST_NORM_READ:  state_in = ST_NORM_START;
         ST_NORM_START: state_in = ST_NORM_WAIT;
         ST_NORM_WAIT:  if (div_done) state_in = last_idx ? ST_IDLE : ST_NORM_READ;
         default:       state_in = ST_IDLE;
      endcase
   end

   // Outputs, memory strobes and divider operands.
   always_comb begin
      busy         = (state_ff != ST_IDLE);
      score_wr     = 1'b0;
      score_rd_en  = 1'b0;
      exp_wr       = 1'b0;
      exp_rd_en    = 1'b0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      rsp_valid    = 1'b0;
      unique case (state_ff)
         ST_IDLE:      score_wr = start && (count_ff < CNT_MAX);
         ST_EXP_READ:  score_rd_en = 1'b1;
         ST_DIV_K: begin
            div_start    = 1'b1;
            div_dividend = DIV_W'(prod_ff[PROD_W-1:8]);
            div_divisor  = DIV_W'(k_ff);
         end
         ST_RECIP: begin
            div_start    = 1'b1;
            div_dividend = RECIP_NUM + DIV_W'(acc_ff[ACC_W-1:1]);
            div_divisor  = DIV_W'(acc_ff);
         end
         ST_EXP_WRITE: exp_wr = 1'b1;
         ST_NORM_READ: exp_rd_en = 1'b1;
         ST_NORM_START: begin
            div_start    = 1'b1;
            div_dividend = DIV_W'({exp_rd, 16'h0000});
            div_divisor  = DIV_W'(total_ff);
         end
         ST_NORM_WAIT: rsp_valid = div_done;
         default: ;
      endcase
      rsp_item.probability = (div_q[DIV_W-1:PROB_W] != '0) ? PROB_MAX : div_q[PROB_W-1:0];
      rsp_item.result_last = last_idx;
      rsp_item.overflowed  = ovf_ff;
   end

   // Datapath next values.
   always_comb begin
      count_in  = count_ff;
      max_in    = max_ff;
      ovf_in    = ovf_ff;
      idx_in    = idx_ff;
      total_in  = total_ff;
      n_in      = n_ff;
      term_in   = term_ff;
      acc_in    = acc_ff;
      prod_in   = prod_ff;
      mplier_in = mplier_ff;
      bit_in    = bit_ff;
      k_in      = k_ff;
      e_in      = e_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (count_ff < CNT_MAX) begin
                  count_in = count_ff + 1'b1;
                  if ($signed(req_item.score) > max_ff) max_in = $signed(req_item.score);
               end else begin
                  ovf_in = 1'b1;
               end
               idx_in   = '0;
               total_in = '0;
            end
         end
         ST_EXP_INIT: begin
            n_in      = n_full[N_W-1:0];
            mplier_in = n_full[N_W-1:0];
            term_in   = TERM_ONE;
            acc_in    = ACC_W'(TERM_ONE);
            k_in      = 7'd1;
            prod_in   = '0;
            bit_in    = '0;
            e_in      = '0;
         end
         ST_MUL: begin
            // Multiplier bits MSB first, one partial product per cycle.
            prod_in   = {prod_ff[PROD_W-2:0], 1'b0}
                        + (mplier_ff[N_W-1] ? PROD_W'(term_ff) : '0);
            mplier_in = {mplier_ff[N_W-2:0], 1'b0};
            bit_in    = bit_ff + 1'b1;
         end
         ST_WAIT_K: begin
            if (div_done) begin
               term_in   = q_term;
               acc_in    = acc_ff + ACC_W'(q_term);
               k_in      = k_ff + 1'b1;
               prod_in   = '0;
               mplier_in = n_ff;
               bit_in    = '0;
            end
         end
         ST_WAIT_RECIP: begin
            if (div_done) e_in = div_q[EXP_W-1:0];
         end
         ST_EXP_WRITE: begin
            total_in = total_ff + TOTAL_W'(e_ff);
            idx_in   = last_idx ? '0 : idx_ff + 1'b1;
         end
         ST_NORM_WAIT: begin
            if (div_done) begin
               idx_in = idx_ff + 1'b1;
               if (last_idx) begin
                  count_in = '0;
                  max_in   = SCORE_MIN;
                  ovf_in   = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         max_ff   <= SCORE_MIN;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         max_ff   <= max_in;
         ovf_ff   <= ovf_in;
      end
      idx_ff    <= idx_in;
      total_ff  <= total_in;
      n_ff      <= n_in;
      term_ff   <= term_in;
      acc_ff    <= acc_in;
      prod_ff   <= prod_in;
      mplier_ff <= mplier_in;
      bit_ff    <= bit_in;
      k_ff      <= k_in;
      e_ff      <= e_in;
   end

   smr_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_LEN)) u_score_ram (
      .clock   (clock),
      .wr_en   (score_wr),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_item.score),
      .rd_en   (score_rd_en),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (score_rd)
   );

   smr_ram #(.WIDTH(EXP_W), .DEPTH(MAX_LEN)) u_exp_ram (
      .clock   (clock),
      .wr_en   (exp_wr),
      .wr_addr (idx_ff[ADDR_W-1:0]),
      .wr_data (e_ff),
      .rd_en   (exp_rd_en),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (exp_rd)
   );

   smr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

`ifndef ASSERT_OFF
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("element count exceeds capacity");
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result shown while idle");
   a_row_end_busy: assert property (@(posedge clock) disable iff (reset)
      accept && req_item.row_end |=> busy)
      else $error("row end did not start computation");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.result_last |=> !busy && count_ff == '0)
      else $error("row state not cleared after last result");
   a_nonlast_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.result_last |=> busy)
      else $error("row ended before its last result");
`endif

endmodule

`default_nettype wire

// ===== rtl/smr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No package dependencies.
`default_nettype none

module smr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/smr_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, shared by the
// series terms, the reciprocal and the normalization. Uses smr_pkg.
`default_nettype none

module smr_div
   import smr_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DIV_W-1:0] dividend,
   input  wire logic [DIV_W-1:0] divisor,
   output logic                  done,
   output logic      [DIV_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIV_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] dvs_ff, dvs_in;
   logic [DIV_W:0]   trial;
   logic [DIV_W:0]   diff;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
      end else if (run_ff) begin
         // Bring down the next dividend bit and subtract when it fits.
         if (!diff[DIV_W]) begin
            rem_in = diff[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== bench/softmax_row_top_test.sv =====
// Self-checking bench for softmax_row_top: drives rows of Q7.8 scores and checks each result
// against a cycle-free predictor of the max-subtracted fixed-point softmax or a typed-in value.
// Depends on smr_pkg and the softmax_row_top RTL.
`timescale 1ns / 1ps

module softmax_row_top_test
   import smr_pkg::*;
;

   localparam int ROW_CAP = 64;

   typedef struct {
      logic [15:0] score;
      logic        row_end;
      bit          typed;
      logic [15:0] prob;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_valid;
   rsp_type rsp_item;

   softmax_row_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   always #2 clock = ~clock;

   // Row state of the predictor.
   logic [15:0]        row_scores[ROW_CAP];
   bit                 row_typed[ROW_CAP];
   logic [15:0]        row_typed_prob[ROW_CAP];
   int                 row_count = 0;
   logic signed [15:0] row_peak = SCORE_MIN;
   bit                 row_dropped = 0;

   rsp_type      pending_probs[$];
   int           error_count = 0;
   int           result_count = 0;
   int           items_sent = 0;
   int           rows_sent = 0;
   bit           quiet_tail = 0;
   stim_row_type directed[$];

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      error_count++;
   endtask

   // e = 65536 * exp(-n/256) by the truncated series and a rounded reciprocal.
   function automatic logic [16:0] exp_weight(input int unsigned n);
      longint unsigned term, acc;
      term = 64'd1 << 36;
      acc = term;
      if (n > 3072) return 17'd0;
      for (int k = 1; k < 128 && term != 0; k++) begin
         term = (term * n) / (256 * k);
         acc += term;
      end
      return 17'(((64'd1 << 52) + acc / 2) / acc);
   endfunction

   task automatic predict_softmax(input req_type item, input bit typed,
                                  input logic [15:0] typed_prob);
      logic [16:0] weights[ROW_CAP];
      logic [22:0] total;
      longint unsigned p;
      rsp_type r;
      if (row_count < ROW_CAP) begin
         row_scores[row_count] = item.score;
         row_typed[row_count] = typed;
         row_typed_prob[row_count] = typed_prob;
         if ($signed(item.score) > row_peak) row_peak = $signed(item.score);
         row_count++;
      end else begin
         row_dropped = 1;
      end
      if (!item.row_end) return;
      total = '0;
      for (int i = 0; i < row_count; i++) begin
         weights[i] = exp_weight(int'(row_peak) - int'($signed(row_scores[i])));
         total = total + 23'(weights[i]);
      end
      for (int i = 0; i < row_count; i++) begin
         p = (longint'(weights[i]) << 16) / total;
         if (p > 65535) p = 65535;
         r.probability = row_typed[i] ? row_typed_prob[i] : 16'(p);
         r.result_last = (i == row_count - 1);
         r.overflowed = row_dropped;
         pending_probs.push_back(r);
      end
      row_count = 0;
      row_peak = SCORE_MIN;
      row_dropped = 0;
      rows_sent++;
   endtask

   task automatic send_score(input logic [15:0] score, input logic row_end,
                             input bit typed = 0, input logic [15:0] typed_prob = '0);
      req_type item;
      item.score = score;
      item.row_end = row_end;
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end else begin
         @(negedge clock);
      end
      start <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy);
      predict_softmax(item, typed, typed_prob);
      items_sent++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_probs.size() == 0) begin
            report_mismatch("result with nothing expected");
         end else begin
            rsp_type want;
            want = pending_probs.pop_front();
            if (rsp_item.probability !== want.probability)
               report_mismatch($sformatf("probability %0d, wanted %0d",
                                         rsp_item.probability, want.probability));
            if (rsp_item.result_last !== want.result_last)
               report_mismatch($sformatf("result_last %b, wanted %b",
                                         rsp_item.result_last, want.result_last));
            if (rsp_item.overflowed !== want.overflowed)
               report_mismatch($sformatf("overflowed %b, wanted %b",
                                         rsp_item.overflowed, want.overflowed));
         end
         result_count++;
      end
   end

   function automatic logic [15:0] clamp_score(input int v);
      if (v > 32767) return 16'h7FFF;
      if (v < -32768) return 16'h8000;
      return 16'(v);
   endfunction

   initial begin
      int len, base, spread, wait_cycles;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Lone element, extremes, a tie, a score past the cutoff, and mixed rows.
      directed = '{
         '{16'h0100, 1'b1, 1, 16'd65535},
         '{16'h7FFF, 1'b0, 1, 16'd65535}, '{16'h8000, 1'b1, 1, 16'd0},
         '{16'h0000, 1'b0, 1, 16'd32768}, '{16'h0000, 1'b1, 1, 16'd32768},
         '{16'h0000, 1'b0, 1, 16'd65535}, '{16'hF300, 1'b1, 1, 16'd0},
         '{16'h0C00, 1'b0, 0, 16'd0}, '{16'h0000, 1'b0, 0, 16'd0},
         '{16'hFFFF, 1'b1, 0, 16'd0},
         '{16'hFF00, 1'b0, 0, 16'd0}, '{16'hFE00, 1'b0, 0, 16'd0},
         '{16'h8001, 1'b1, 0, 16'd0}
      };
      foreach (directed[i])
         send_score(directed[i].score, directed[i].row_end, directed[i].typed,
                    directed[i].prob);

      // Too-long row whose row_end item is itself dropped.
      for (int i = 0; i < 66; i++) send_score(16'h0000, i == 65, 1, 16'd1024);

      while (items_sent < 470) begin
         if (items_sent > 410) quiet_tail = 1;
         len = ($urandom_range(0, 39) == 0) ? $urandom_range(62, 68) : $urandom_range(1, 8);
         base = int'($signed(16'($urandom)));
         spread = ($urandom_range(0, 4) == 0) ? 4000 : 1024;
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 19) == 0)
               send_score(16'($urandom), i == len - 1);
            else
               send_score(clamp_score(base + $urandom_range(0, spread) - spread / 2),
                          i == len - 1);
         end
      end

      @(negedge clock);
      start <= 1'b0;
      wait_cycles = 0;
      while (pending_probs.size() != 0 && wait_cycles < 2000000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (200) @(posedge clock);
      $display("Sent %0d scores in %0d rows; %0d probabilities checked.",
               items_sent, rows_sent, result_count);
      if (error_count == 0 && pending_probs.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches, %0d results missing", error_count, pending_probs.size());
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #(64'd200_000_000);
      $display("run timed out");
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/smr_pkg.sv
rtl/smr_ram.sv
rtl/smr_div.sv
rtl/softmax_row_top.sv
bench/softmax_row_top_test.sv
